// ===== rtl/avs_pkg.sv =====
// Shared types, constants and character helpers for the alphanumeric shift cipher.
package avs_pkg;

    localparam int KEY_MAX     = 16;
    localparam int KEY_POS_W   = 4;
    localparam int KEY_LEN_W   = 5;
    localparam int CHAR_W      = 8;
    localparam int SHIFT_W     = 5;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 64;

    localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [CHAR_W-1:0] CHAR_DIGIT_0 = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_DIGIT_9 = 8'h39;

    localparam logic [SHIFT_W-1:0] LETTER_MOD = 5'd26;
    localparam logic [SHIFT_W-1:0] DIGIT_MOD  = 5'd10;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_KEY_LOW    = 2'd0,
        CFG_KEY_HIGH   = 2'd1,
        CFG_KEY_LENGTH = 2'd2,
        CFG_DECRYPT    = 2'd3
    } cfg_reg_t;

    typedef enum logic [1:0] {
        CLS_NONE  = 2'd0,
        CLS_UPPER = 2'd1,
        CLS_LOWER = 2'd2,
        CLS_DIGIT = 2'd3
    } char_class_t;

    typedef struct packed {
        logic [CHAR_W-1:0]  data_char;
        char_class_t        cls;
        logic [SHIFT_W-1:0] shift;
        logic               decrypt;
    } item_t;

    function automatic char_class_t classify(input logic [CHAR_W-1:0] c);
        char_class_t cls;
        if (c inside {[CHAR_UPPER_A:CHAR_UPPER_Z]})
            cls = CLS_UPPER;
        else if (c inside {[CHAR_LOWER_A:CHAR_LOWER_Z]})
            cls = CLS_LOWER;
        else if (c inside {[CHAR_DIGIT_0:CHAR_DIGIT_9]})
            cls = CLS_DIGIT;
        else
            cls = CLS_NONE;
        return cls;
    endfunction

    function automatic logic [CHAR_W-1:0] class_base(input char_class_t cls);
        logic [CHAR_W-1:0] base;
        case (cls)
            CLS_UPPER: base = CHAR_UPPER_A;
            CLS_LOWER: base = CHAR_LOWER_A;
            CLS_DIGIT: base = CHAR_DIGIT_0;
            default:   base = '0;
        endcase
        return base;
    endfunction

endpackage

// ===== rtl/avs_front.sv =====
// Front end: accepts bytes, tracks the key position and classifies data and key.
module avs_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [avs_pkg::CHAR_W-1:0]    data_char,
    input  logic                          restart,
    input  logic [avs_pkg::CFG_DATA_W-1:0] key_low,
    input  logic [avs_pkg::CFG_DATA_W-1:0] key_high,
    input  logic [avs_pkg::KEY_LEN_W-1:0] key_length,
    input  logic                          decrypt,
    input  logic                          queue_full,
    output logic                          push,
    output avs_pkg::item_t                push_item
);
    import avs_pkg::*;

    logic [KEY_POS_W-1:0]      pos_reg;
    logic [KEY_POS_W-1:0]      pos_next;
    logic [KEY_POS_W-1:0]      pos_base;
    logic [KEY_POS_W-1:0]      pos_use;
    logic [KEY_LEN_W-1:0]      pos_inc;
    logic [KEY_LEN_W-1:0]      eff_len;
    logic [2*CFG_DATA_W-1:0]   key_all;
    logic [CHAR_W-1:0]         key_char;
    char_class_t               key_cls;
    char_class_t               data_cls;
    logic [CHAR_W-1:0]         key_diff;
    logic [SHIFT_W-1:0]        key_shift;
    logic [SHIFT_W-1:0]        shift_red;

    assign in_stall = queue_full;
    assign push     = in_valid && !queue_full;
    assign key_all  = {key_high, key_low};

    always_comb
    begin
        if (key_length == '0)
            eff_len = KEY_LEN_W'(1);
        else if (key_length > KEY_LEN_W'(KEY_MAX))
            eff_len = KEY_LEN_W'(KEY_MAX);
        else
            eff_len = key_length;
    end

    // A position left beyond a shortened key wraps to the first character.
    always_comb
    begin
        pos_base = restart ? '0 : pos_reg;
        pos_use  = ({1'b0, pos_base} >= eff_len) ? '0 : pos_base;
        pos_inc  = {1'b0, pos_use} + KEY_LEN_W'(1);
        pos_next = (pos_inc >= eff_len) ? '0 : pos_inc[KEY_POS_W-1:0];
    end

    always_comb
    begin
        key_char  = key_all[{pos_use, 3'b000} +: CHAR_W];
        key_cls   = classify(key_char);
        key_diff  = key_char - class_base(key_cls);
        key_shift = (key_cls == CLS_NONE) ? '0 : key_diff[SHIFT_W-1:0];
        data_cls  = classify(data_char);
        // Digit data takes the key shift modulo 10; the shift is at most 25.
        shift_red = key_shift;
        if (data_cls == CLS_DIGIT)
        begin
            if (key_shift >= SHIFT_W'(20))
                shift_red = key_shift - SHIFT_W'(20);
            else if (key_shift >= DIGIT_MOD)
                shift_red = key_shift - DIGIT_MOD;
        end
    end

    always_comb
    begin
        push_item.data_char = data_char;
        push_item.cls       = data_cls;
        push_item.shift     = shift_red;
        push_item.decrypt   = decrypt;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pos_reg <= '0;
        else if (push)
            pos_reg <= pos_next;
    end

endmodule

// ===== rtl/avs_queue.sv =====
// Two-entry queue between the front end and the back end.
module avs_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  avs_pkg::item_t push_item,
    output logic           full,
    input  logic           pop,
    output logic           head_valid,
    output avs_pkg::item_t head_item
);
    import avs_pkg::*;

    item_t       entry_reg [2];
    logic [1:0]  count_reg;
    logic [1:0]  count_next;
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_item  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_item;
    end

endmodule

// ===== rtl/avs_back.sv =====
// Back end: applies the shift with wrap-around and holds the result register.
module avs_back (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       head_valid,
    input  avs_pkg::item_t             head_item,
    output logic                       pop,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [avs_pkg::CHAR_W-1:0] out_char
);
    import avs_pkg::*;

    logic                 out_valid_reg;
    logic [CHAR_W-1:0]    out_char_reg;
    logic [CHAR_W-1:0]    result;
    logic [CHAR_W-1:0]    base;
    logic [CHAR_W-1:0]    alpha_full;
    logic [SHIFT_W-1:0]   modulus;
    logic [SHIFT_W:0]     sum;
    logic [SHIFT_W:0]     wrapped;

    assign pop       = head_valid && (!out_valid_reg || !out_stall);
    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;

    always_comb
    begin
        base       = class_base(head_item.cls);
        modulus    = (head_item.cls == CLS_DIGIT) ? DIGIT_MOD : LETTER_MOD;
        alpha_full = head_item.data_char - base;
        // Both sums stay below twice the modulus, so one subtract wraps them.
        if (head_item.decrypt)
            sum = {1'b0, alpha_full[SHIFT_W-1:0]} + {1'b0, modulus}
                  - {1'b0, head_item.shift};
        else
            sum = {1'b0, alpha_full[SHIFT_W-1:0]} + {1'b0, head_item.shift};
        wrapped = (sum >= {1'b0, modulus}) ? sum - {1'b0, modulus} : sum;
        if (head_item.cls == CLS_NONE)
            result = head_item.data_char;
        else
            result = base + CHAR_W'(wrapped);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (pop)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            out_char_reg <= result;
    end

endmodule

// ===== rtl/alnum_vigenere_shift_core.sv =====
// Top level of the alphanumeric shift cipher: configuration registers and datapath.
//
// Each accepted byte is shifted by one key character, the key cycling over
// key_length characters (zero counts as one, above 16 as 16); letters wrap
// modulo 26 and digits modulo 10 within their class, and every other byte
// passes through while still using a key position. The block takes one byte
// per cycle while the queue is not full: the key position register is the
// front end's only loop and it advances once per transfer. An accepted byte
// waits in a two-entry queue and moves into the output register when that
// register is empty or its result is taken; while it holds a stalled result,
// the input keeps taking transfers until the queue holds two bytes.
module alnum_vigenere_shift_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [avs_pkg::CHAR_W-1:0]     data_char,
    input  logic                           restart,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [avs_pkg::CHAR_W-1:0]     out_char,
    input  logic                           cfg_write_en,
    input  logic [avs_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [avs_pkg::CFG_DATA_W-1:0] cfg_data
);
    import avs_pkg::*;

    logic [CFG_DATA_W-1:0] key_low_reg;
    logic [CFG_DATA_W-1:0] key_high_reg;
    logic [KEY_LEN_W-1:0]  key_length_reg;
    logic                  decrypt_reg;
    logic                  push;
    item_t                 push_item;
    logic                  queue_full;
    logic                  pop;
    logic                  head_valid;
    item_t                 head_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_low_reg    <= '0;
            key_high_reg   <= '0;
            key_length_reg <= KEY_LEN_W'(1);
            decrypt_reg    <= 1'b0;
        end
        else if (cfg_write_en)
        begin
            case (cfg_reg_t'(cfg_index))
                CFG_KEY_LOW:    key_low_reg    <= cfg_data;
                CFG_KEY_HIGH:   key_high_reg   <= cfg_data;
                CFG_KEY_LENGTH: key_length_reg <= cfg_data[KEY_LEN_W-1:0];
                CFG_DECRYPT:    decrypt_reg    <= cfg_data[0];
                default:        ;
            endcase
        end
    end

    avs_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .data_char  (data_char),
        .restart    (restart),
        .key_low    (key_low_reg),
        .key_high   (key_high_reg),
        .key_length (key_length_reg),
        .decrypt    (decrypt_reg),
        .queue_full (queue_full),
        .push       (push),
        .push_item  (push_item)
    );

    avs_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    avs_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_item  (head_item),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_char   (out_char)
    );

endmodule

// ===== test/alnum_vigenere_shift_checker.sv =====
// Checker for the shift cipher: tracks the key state, predicts each output byte and compares.
`timescale 1ns / 100ps

module alnum_vigenere_shift_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    input  logic                             in_stall,
    input  logic [avs_pkg::CHAR_W-1:0]       data_char,
    input  logic                             restart,
    input  logic                             out_valid,
    input  logic                             out_stall,
    input  logic [avs_pkg::CHAR_W-1:0]       out_char,
    input  logic                             cfg_write_en,
    input  logic [avs_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [avs_pkg::CFG_DATA_W-1:0]   cfg_data,
    output int                               fail_count,
    output int                               pending_count
);
    import avs_pkg::*;

    logic [CFG_DATA_W-1:0] key_low;
    logic [CFG_DATA_W-1:0] key_high;
    logic [KEY_LEN_W-1:0]  key_len;
    logic                  decrypting;
    logic [KEY_POS_W-1:0]  key_pos;
    logic [CHAR_W-1:0]     cipher_q[$];

    // A key character shifts by its offset within its own class; anything else shifts by zero.
    function automatic int key_shift(input logic [CHAR_W-1:0] k);
        int s;
        s = 0;
        if (k >= CHAR_UPPER_A && k <= CHAR_UPPER_Z)
            s = k - CHAR_UPPER_A;
        else if (k >= CHAR_LOWER_A && k <= CHAR_LOWER_Z)
            s = k - CHAR_LOWER_A;
        else if (k >= CHAR_DIGIT_0 && k <= CHAR_DIGIT_9)
            s = k - CHAR_DIGIT_0;
        return s;
    endfunction

    function automatic logic [CHAR_W-1:0] shift_char(input logic [CHAR_W-1:0] c,
                                                      input int shift, input logic dec);
        int base;
        int span;
        int ofs;
        int amount;
        base = 0;
        span = 0;
        if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z)
        begin
            base = CHAR_UPPER_A;
            span = LETTER_MOD;
        end
        else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z)
        begin
            base = CHAR_LOWER_A;
            span = LETTER_MOD;
        end
        else if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9)
        begin
            base = CHAR_DIGIT_0;
            span = DIGIT_MOD;
        end
        if (span == 0)
            return c;
        amount = shift % span;
        ofs = int'(c) - base;
        if (dec)
            ofs = (ofs + span - amount) % span;
        else
            ofs = (ofs + amount) % span;
        return CHAR_W'(base + ofs);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        int len;
        int pos;
        logic [2*CFG_DATA_W-1:0] key_all;
        logic [CHAR_W-1:0] want;
        if (!rst_n)
        begin
            key_low = '0;
            key_high = '0;
            key_len = KEY_LEN_W'(1);
            decrypting = 1'b0;
            key_pos = '0;
            cipher_q.delete();
            fail_count = 0;
            pending_count <= 0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                case (cfg_reg_t'(cfg_index))
                    CFG_KEY_LOW:    key_low = cfg_data;
                    CFG_KEY_HIGH:   key_high = cfg_data;
                    CFG_KEY_LENGTH: key_len = cfg_data[KEY_LEN_W-1:0];
                    CFG_DECRYPT:    decrypting = cfg_data[0];
                    default: ;
                endcase
            end

            if (in_valid && !in_stall)
            begin
                len = (key_len == 0) ? 1 : ((key_len > KEY_MAX) ? KEY_MAX : int'(key_len));
                pos = restart ? 0 : int'(key_pos);
                // A position left past the end by a shorter key starts over
                // at the first character.
                if (pos >= len)
                    pos = 0;
                key_all = {key_high, key_low};
                cipher_q.push_back(shift_char(data_char, key_shift(key_all[pos*8 +: 8]),
                                              decrypting));
                pos = pos + 1;
                if (pos >= len)
                    pos = 0;
                key_pos = KEY_POS_W'(pos);
            end

            if (out_valid && !out_stall)
            begin
                if (cipher_q.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: out_char expected none, actual %h", $time, out_char);
                end
                else
                begin
                    want = cipher_q.pop_front();
                    if (out_char !== want)
                    begin
                        fail_count++;
                        $display("%0t: out_char expected %h, actual %h",
                                 $time, want, out_char);
                    end
                end
            end
            pending_count <= cipher_q.size();
        end
    end

endmodule

// ===== test/alnum_vigenere_shift_core_tb.sv =====
// Testbench top for the shift cipher: clock, reset, stimulus, receiver stalls and verdict.
`timescale 1ns / 100ps

module alnum_vigenere_shift_core_tb;
    import avs_pkg::*;

    localparam int RESET_CYCLES    = 9;
    localparam int LIMIT_CYCLES    = 200000;
    localparam int RANDOM_PHASES   = 10;
    localparam int PHASE_BYTES     = 165;
    localparam int HOLD_OFF_CYCLES = 300;

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_stall;
    logic [CHAR_W-1:0]      data_char;
    logic                   restart;
    logic                   out_valid;
    logic                   out_stall;
    logic [CHAR_W-1:0]      out_char;
    logic                   cfg_write_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    int fail_count;
    int pending_count;
    int in_gap_pct = 0;
    int out_stall_pct = 0;
    int hold_off_left = 0;
    int cycle_count = 0;

    alnum_vigenere_shift_core DUT (.*);

    alnum_vigenere_shift_checker cipher_check (.*);

    always begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // A pause comes with a chance of pct percent: usually a short one, now and then a long one.
    function automatic int idle_span(input int pct);
        if ($urandom_range(0, 99) >= pct)
            return 0;
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(12, 40);
        return $urandom_range(1, 3);
    endfunction

    function automatic logic [CHAR_W-1:0] random_char();
        case ($urandom_range(0, 9))
            0, 1:    return CHAR_W'($urandom_range(0, 255));
            2, 3, 4: return CHAR_UPPER_A + CHAR_W'($urandom_range(0, 25));
            5, 6, 7: return CHAR_LOWER_A + CHAR_W'($urandom_range(0, 25));
            default: return CHAR_DIGIT_0 + CHAR_W'($urandom_range(0, 9));
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] random_key_word();
        logic [CFG_DATA_W-1:0] w;
        for (int i = 0; i < 8; i++)
            w[i*8 +: 8] = random_char();
        return w;
    endfunction

    task automatic send_byte(input logic [CHAR_W-1:0] c, input logic rs);
        int gap;
        gap = idle_span(in_gap_pct);
        in_valid <= 1'b1;
        data_char <= c;
        restart <= rs;
        do
            @(posedge clk);
        while (in_stall);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], 1'b0);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
        cfg_write_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        @(posedge clk);
    endtask

    task automatic configure(input logic [CFG_DATA_W-1:0] lo, input logic [CFG_DATA_W-1:0] hi,
                             input int len, input logic dec);
        write_reg(CFG_KEY_LOW, lo);
        write_reg(CFG_KEY_HIGH, hi);
        write_reg(CFG_KEY_LENGTH, CFG_DATA_W'(len));
        write_reg(CFG_DECRYPT, CFG_DATA_W'(dec));
    endtask

    // Registers are only touched once every expected byte has come back.
    task automatic wait_idle();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_count != 0);
        repeat (4) @(posedge clk);
    endtask

    initial begin
        int stall_left;
        stall_left = 0;
        out_stall = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_off_left > 0) begin
                out_stall <= 1'b1;
                hold_off_left--;
                stall_left = 0;
            end else if (stall_left > 0) begin
                stall_left--;
            end else begin
                stall_left = idle_span(out_stall_pct);
                out_stall <= (stall_left > 0);
                if (stall_left > 0)
                    stall_left--;
            end
        end
    end

    initial begin
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("%0t: timeout after %0d cycles", $time, LIMIT_CYCLES);
        $display("** alnum_vigenere_shift_core: FAILED **");
        $finish;
    end

    initial begin
        logic [CFG_DATA_W-1:0] lo;
        logic [CFG_DATA_W-1:0] hi;
        int len;
        logic dec;
        rst_n = 1'b0;
        in_valid = 1'b0;
        data_char = '0;
        restart = 1'b0;
        cfg_write_en = 1'b0;
        cfg_index = CFG_KEY_LOW;
        cfg_data = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The key resets to zero bytes, which do not shift at all.
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte("M", 1'b0);
        wait_idle();

        // Key text "Zz9a!0Mb" then "Q1x~7yB#", all sixteen characters in use.
        configure(64'h624D_3021_6139_7A5A, 64'h2342_7937_7E78_3151, 16, 1'b0);
        send_byte("A", 1'b1);
        send_text("zY9Z05");
        send_byte(8'h80, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte("0", 1'b0);
        wait_idle();

        // The key position is now past a three character key and must wrap.
        write_reg(CFG_KEY_LENGTH, CFG_DATA_W'(3));
        write_reg(CFG_DECRYPT, CFG_DATA_W'(1));
        send_text("b5Y");
        wait_idle();
        write_reg(CFG_KEY_LENGTH, CFG_DATA_W'(0));
        send_text("Mm");
        wait_idle();
        write_reg(CFG_KEY_LENGTH, CFG_DATA_W'(31));
        send_text("q8");
        send_byte("g", 1'b1);

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            wait_idle();
            case (p)
                0: begin
                    lo = {8{8'h7A}};
                    hi = lo;
                    len = 16;
                end
                1: begin
                    lo = '1;
                    hi = '1;
                    len = 1;
                end
                2: begin
                    lo = {8{8'h39}};
                    hi = random_key_word();
                    len = 0;
                end
                3: begin
                    lo = random_key_word();
                    hi = random_key_word();
                    len = 31;
                end
                default: begin
                    lo = random_key_word();
                    hi = random_key_word();
                    len = $urandom_range(0, 31);
                end
            endcase
            dec = (p < 4) ? p[0] : 1'($urandom_range(0, 1));
            configure(lo, hi, len, dec);

            in_gap_pct = (p % 3 == 0) ? 0 : $urandom_range(10, 60);
            out_stall_pct = (p % 4 == 1) ? 0 : $urandom_range(10, 60);
            // The receiver holds off while bytes keep coming, so the block fills and stalls.
            if (p == 5) begin
                in_gap_pct = 0;
                hold_off_left = HOLD_OFF_CYCLES;
            end

            for (int n = 0; n < PHASE_BYTES; n++)
                send_byte(random_char(), ($urandom_range(0, 15) == 0));
        end

        wait_idle();
        if (fail_count == 0)
            $display("** alnum_vigenere_shift_core: PASSED **");
        else
            $display("** alnum_vigenere_shift_core: FAILED **");
        $finish;
    end

endmodule

// ===== alnum_vigenere_shift_core.f =====
rtl/avs_pkg.sv
rtl/avs_front.sv
rtl/avs_queue.sv
rtl/avs_back.sv
rtl/alnum_vigenere_shift_core.sv
test/alnum_vigenere_shift_checker.sv
test/alnum_vigenere_shift_core_tb.sv
